// ----- rtl/npcs_pkg.sv -----
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int ColorW   = 8;
  localparam int EntryW   = 4 * ColorW;
  localparam int IndexW   = 8;
  localparam int CountW   = 9;
  localparam int SqW      = 2 * ColorW;
  localparam int DistW    = SqW + 2;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // larger than any squared RGB distance
  localparam logic [DistW-1:0] StartDist = '1;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdWrite  = 1'b1;

  // register index taken from paddr[2]
  localparam logic RegPaletteCount = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } npcs_state_t;

  typedef struct packed {
    logic accept;
    logic hit;
    logic issue;
    logic finish;
  } npcs_cmd_t;

  typedef struct packed {
    logic hit;
    logic cnt_zero;
    logic last_addr;
    logic found;
    logic busy;
    logic out_free;
  } npcs_sts_t;

endpackage

// ----- rtl/npcs_ram.sv -----
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/npcs_dp.sv -----
// ----------------------------------------------------------------------------
// npcs_dp
// Datapath: palette memory with valid bits, remembered-entry check, pipelined
// squared distance scan, best-entry tracking and output register.
// ----------------------------------------------------------------------------
module npcs_dp import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  npcs_cmd_t         cmd,
  output npcs_sts_t         sts,
  input  logic [CountW-1:0] palette_count,
  input  logic              in_cmd,
  input  logic [IndexW-1:0] in_entry_index,
  input  logic [ColorW-1:0] in_red,
  input  logic [ColorW-1:0] in_green,
  input  logic [ColorW-1:0] in_blue,
  input  logic [ColorW-1:0] in_alpha,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [IndexW-1:0] out_palette_index
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [CountW-1:0] NumEntries = CountW'(PALETTE_ENTRIES);

  logic [EntryW-1:0]          pix_r;
  logic [EntryW-1:0]          in_pix;
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic                       rvld_r;
  logic                       we;
  logic [AW-1:0]              raddr;
  logic [EntryW-1:0]          ram_q;
  logic [EntryW-1:0]          pal_q;
  logic [CountW-1:0]          cnt_eff;
  logic [CountW-1:0]          scan_addr_r;
  logic [IndexW-1:0]          last_index_r;
  logic [IndexW-1:0]          best_r;
  logic [DistW-1:0]           best_dist_r;
  logic                       found_r;
  logic                       s1_vld_r;
  logic [IndexW-1:0]          s1_idx_r;
  logic                       s2_vld_r;
  logic [IndexW-1:0]          s2_idx_r;
  logic [SqW-1:0]             sq_r_r;
  logic [SqW-1:0]             sq_g_r;
  logic [SqW-1:0]             sq_b_r;
  logic [ColorW-1:0]          d_r;
  logic [ColorW-1:0]          d_g;
  logic [ColorW-1:0]          d_b;
  logic [DistW-1:0]           dist_sum;
  logic                       out_vld_r;
  logic [IndexW-1:0]          out_idx_r;

  assign in_pix = {in_alpha, in_red, in_green, in_blue};
  assign we     = cmd.accept && (in_cmd == CmdWrite) &&
                  ({1'b0, in_entry_index} < NumEntries);
  assign raddr  = cmd.issue ? scan_addr_r[AW-1:0] : last_index_r[AW-1:0];

  npcs_ram #(
    .WIDTH (EntryW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (in_entry_index[AW-1:0]),
    .wdata (in_pix),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[in_entry_index[AW-1:0]] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  // unwritten entries read as zero
  assign pal_q   = rvld_r ? ram_q : '0;
  assign cnt_eff = (palette_count > NumEntries) ? NumEntries : palette_count;

  assign d_r = (pal_q[23:16] > pix_r[23:16]) ? pal_q[23:16] - pix_r[23:16]
                                             : pix_r[23:16] - pal_q[23:16];
  assign d_g = (pal_q[15:8] > pix_r[15:8]) ? pal_q[15:8] - pix_r[15:8]
                                           : pix_r[15:8] - pal_q[15:8];
  assign d_b = (pal_q[7:0] > pix_r[7:0]) ? pal_q[7:0] - pix_r[7:0]
                                         : pix_r[7:0] - pal_q[7:0];

  assign dist_sum = DistW'(sq_r_r) + DistW'(sq_g_r) + DistW'(sq_b_r);

  always_ff @(posedge clk) begin
    sq_r_r   <= SqW'(d_r) * SqW'(d_r);
    sq_g_r   <= SqW'(d_g) * SqW'(d_g);
    sq_b_r   <= SqW'(d_b) * SqW'(d_b);
    s1_idx_r <= scan_addr_r[IndexW-1:0];
    s2_idx_r <= s1_idx_r;
    if (cmd.accept) begin
      pix_r       <= in_pix;
      scan_addr_r <= '0;
      best_r      <= '0;
      best_dist_r <= StartDist;
    end else if (cmd.hit) begin
      best_r <= last_index_r;
    end else begin
      if (cmd.issue) begin
        scan_addr_r <= scan_addr_r + CountW'(1);
      end
      if (s2_vld_r && !found_r && (dist_sum == '0 || dist_sum < best_dist_r)) begin
        best_r      <= s2_idx_r;
        best_dist_r <= dist_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      last_index_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
      if (cmd.accept) begin
        found_r <= 1'b0;
      end else if (s2_vld_r && dist_sum == '0) begin
        found_r <= 1'b1;
      end
      if (cmd.finish) begin
        last_index_r <= best_r;
        out_vld_r    <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_idx_r <= best_r;
    end
  end

  assign sts.hit       = (pal_q == pix_r);
  assign sts.cnt_zero  = (cnt_eff == '0);
  assign sts.last_addr = (scan_addr_r == cnt_eff - CountW'(1));
  assign sts.found     = found_r;
  assign sts.busy      = s1_vld_r || s2_vld_r;
  assign sts.out_free  = !out_vld_r || out_ready;

  assign out_valid         = out_vld_r;
  assign out_palette_index = out_idx_r;

endmodule

// ----- rtl/npcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// npcs_ctrl
// Controller: sequences request intake, remembered-entry check, scan and
// result hand-off.
// ----------------------------------------------------------------------------
module npcs_ctrl import npcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  input  npcs_sts_t sts,
  output npcs_cmd_t cmd
);

  npcs_state_t state_r;
  npcs_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_cmd == CmdLookup) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (sts.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_DONE;
        end else if (sts.cnt_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.found) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          if (sts.last_addr) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/nearest_palette_color_search_top.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette store and nearest-color lookup with a remembered last answer.
// ----------------------------------------------------------------------------
// A write request stores one BGRA palette entry. A lookup request is answered
// from the remembered entry when the pixel equals it, and otherwise by a scan
// of count entries at most (fewer on an exact match), where count is
// palette_count clamped to PALETTE_ENTRIES: the scan reads one palette entry
// per cycle from the single read port of the palette RAM into a two-stage
// distance pipeline. One request is processed at a time; a finished result
// waits in the output register while the next request is accepted. The
// palette reads as all zeros after reset through per-entry valid bits, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [IndexW-1:0]   in_entry_index,
  input  logic [ColorW-1:0]   in_red,
  input  logic [ColorW-1:0]   in_green,
  input  logic [ColorW-1:0]   in_blue,
  input  logic [ColorW-1:0]   in_alpha,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IndexW-1:0]   out_palette_index,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  npcs_cmd_t         cmd;
  npcs_sts_t         sts;
  logic [CountW-1:0] count_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr && paddr[2] == RegPaletteCount) begin
      count_r <= pwdata[CountW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegPaletteCount) ? ApbDataW'(count_r) : '0;

  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  npcs_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .palette_count     (count_r),
    .in_cmd            (in_cmd),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_palette_index (out_palette_index)
  );

  a_scan_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_ready)
    else $error("scan pipeline busy while accepting requests");

  a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CmdLookup) |=> !in_ready)
    else $error("request accepted during lookup");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished lookup did not present a result");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_palette_index} < CountW'(PALETTE_ENTRIES)))
    else $error("result index beyond palette");

endmodule

// ----- tb/npcs_result_checker.sv -----
// ----------------------------------------------------------------------------
// npcs_result_checker
// Watches the request, result and register ports of the nearest palette color
// search block, keeps its own copy of the palette, the remembered answer and
// the search count, predicts the palette index of every lookup request and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module npcs_result_checker import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_cmd,
  input  logic [IndexW-1:0]   in_entry_index,
  input  logic [ColorW-1:0]   in_red,
  input  logic [ColorW-1:0]   in_green,
  input  logic [ColorW-1:0]   in_blue,
  input  logic [ColorW-1:0]   in_alpha,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [IndexW-1:0]   out_palette_index,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int unsigned         errors,
  output int unsigned         pending
);

  localparam int          MaxReports    = 10;
  localparam int unsigned StartDistance = 32'h7FFF_FFFF;

  logic [EntryW-1:0] palette_copy [PALETTE_ENTRIES];
  logic [IndexW-1:0] last_answer;
  logic [CountW-1:0] search_count;
  logic [IndexW-1:0] expected_index_q [$];
  logic [EntryW-1:0] pixel_word;
  logic [IndexW-1:0] answer;
  logic [IndexW-1:0] oldest;

  function automatic int unsigned sq_diff(logic [ColorW-1:0] x, logic [ColorW-1:0] y);
    int unsigned d;
    d = (x > y) ? int'(x - y) : int'(y - x);
    return d * d;
  endfunction

  function automatic logic [IndexW-1:0] nearest_entry(logic [EntryW-1:0] pixel);
    int unsigned       limit;
    int unsigned       dist_sum;
    int unsigned       best_dist;
    logic [IndexW-1:0] best;
    logic [EntryW-1:0] e;
    if (int'(last_answer) < PALETTE_ENTRIES && palette_copy[last_answer] == pixel)
      return last_answer;
    limit = (search_count > PALETTE_ENTRIES) ? PALETTE_ENTRIES : search_count;
    best = '0;
    best_dist = StartDistance;
    for (int i = 0; i < limit; i++) begin
      e = palette_copy[i];
      dist_sum = sq_diff(e[ColorW-1:0], pixel[ColorW-1:0])
               + sq_diff(e[2*ColorW-1:ColorW], pixel[2*ColorW-1:ColorW])
               + sq_diff(e[3*ColorW-1:2*ColorW], pixel[3*ColorW-1:2*ColorW]);
      if (dist_sum == 0) return IndexW'(i);
      if (dist_sum < best_dist) begin
        best_dist = dist_sum;
        best = IndexW'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (palette_copy[i]) palette_copy[i] = '0;
      last_answer = '0;
      search_count = '0;
      expected_index_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegPaletteCount)
        search_count = pwdata[CountW-1:0];

      if (out_valid && out_ready) begin
        if (expected_index_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("unexpected result: palette_index %0d", out_palette_index);
        end else begin
          oldest = expected_index_q.pop_front();
          if (out_palette_index !== oldest) begin
            errors++;
            if (errors <= MaxReports)
              $display("mismatch: palette_index expected %0d, got %0d",
                       oldest, out_palette_index);
          end
        end
      end

      if (in_valid && in_ready) begin
        pixel_word = {in_alpha, in_red, in_green, in_blue};
        if (in_cmd == CmdWrite) begin
          if (int'(in_entry_index) < PALETTE_ENTRIES)
            palette_copy[in_entry_index] = pixel_word;
        end else begin
          answer = nearest_entry(pixel_word);
          last_answer = answer;
          expected_index_q.push_back(answer);
        end
      end
    end
    pending <= expected_index_q.size();
  end

endmodule

// ----- tb/nearest_palette_color_search_top_tb.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top_tb
// Drives palette writes and pixel lookups into the nearest palette color
// search block under several search counts and idle patterns on both
// channels, with a result checker beside the block, and prints the verdict.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top_tb;
  import npcs_pkg::*;

  localparam int Entries      = 256;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 20;
  localparam int DrainCycles  = 300;
  localparam int StallLimit   = 5000;
  localparam int PerCount     = 46;

  localparam logic [ApbAddrW-1:0] CountAddr = {RegPaletteCount, 2'b00};
  localparam logic [ApbAddrW-1:0] SpareAddr = {~RegPaletteCount, 2'b00};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_cmd;
  logic [IndexW-1:0]   in_entry_index;
  logic [ColorW-1:0]   in_red;
  logic [ColorW-1:0]   in_green;
  logic [ColorW-1:0]   in_blue;
  logic [ColorW-1:0]   in_alpha;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IndexW-1:0]   out_palette_index;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned quiet_cycles  = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cur_count;

  logic [EntryW-1:0] shadow_palette [Entries];
  logic [EntryW-1:0] prev_pixel;
  int unsigned       count_plan [8] = '{16, 4, 64, 256, 2, 0, 511, 33};

  nearest_palette_color_search_top #(
    .PALETTE_ENTRIES(Entries)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_entry_index(in_entry_index), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_ready(out_ready), .out_palette_index(out_palette_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  npcs_result_checker #(
    .PALETTE_ENTRIES(Entries)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_entry_index(in_entry_index), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_ready(out_ready), .out_palette_index(out_palette_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hold off the result channel on request, else stall at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic cmd, logic [IndexW-1:0] idx, logic [EntryW-1:0] color);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= idx;
    in_alpha       <= color[4*ColorW-1:3*ColorW];
    in_red         <= color[3*ColorW-1:2*ColorW];
    in_green       <= color[2*ColorW-1:ColorW];
    in_blue        <= color[ColorW-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_entry(logic [IndexW-1:0] idx, logic [EntryW-1:0] color);
    send_request(CmdWrite, idx, color);
    shadow_palette[idx] = color;
  endtask

  task automatic lookup(logic [EntryW-1:0] color);
    send_request(CmdLookup, IndexW'($urandom_range(0, Entries - 1)), color);
    prev_pixel = color;
  endtask

  // drop valid and hold until every result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(logic [ApbAddrW-1:0] addr, int unsigned value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ApbDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CountAddr)
      cur_count = (value[CountW-1:0] > Entries) ? Entries : value[CountW-1:0];
  endtask

  function automatic logic [ColorW-1:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return ColorW'($urandom_range(0, 3));
      3: return ColorW'($urandom_range(252, 255));
      default: return ColorW'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_entry();
    if (cur_count > 0 && $urandom_range(0, 3) != 0)
      return $urandom_range(0, cur_count - 1);
    return $urandom_range(0, Entries - 1);
  endfunction

  task automatic random_request();
    logic [EntryW-1:0] color;
    int unsigned       idx;
    if ($urandom_range(0, 99) < 35) begin
      idx = pick_entry();
      if ($urandom_range(0, 3) == 0)
        color = {rand_channel(), shadow_palette[pick_entry()][3*ColorW-1:0]};
      else
        color = {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
      write_entry(IndexW'(idx), color);
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    color = prev_pixel;
        2, 3, 4: color = shadow_palette[pick_entry()];
        5:       color = {rand_channel(), shadow_palette[pick_entry()][3*ColorW-1:0]};
        default: color = {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
      endcase
      lookup(color);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CmdLookup;
    in_entry_index = '0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    in_alpha       = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    prev_pixel     = '0;
    cur_count      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(CountAddr, 0);
    lookup(32'h0000_0000);
    lookup(32'h0401_0203);
    write_entry(8'd0, 32'hFFFF_FFFF);
    write_entry(8'd255, 32'h280A_141E);
    write_entry(8'd128, 32'h07C8_6432);
    write_entry(8'd2, 32'h09C8_6432);
    write_entry(8'd1, 32'h0001_0101);
    cfg_write(CountAddr, 256);
    lookup(32'h280A_141E);
    lookup(32'h280A_141E);
    lookup(32'h630A_141E);
    lookup(32'h00C8_6432);
    lookup(32'h8080_8080);
    lookup(32'hFFFF_FFFF);
    lookup(32'h280A_141E);
    cfg_write(CountAddr, 1);
    lookup(32'h280A_141E);
    lookup(32'h0909_0909);
    cfg_write(SpareAddr, 5);
    lookup(32'h0102_0304);
    cfg_write(CountAddr, 511);
    lookup(32'h00FE_FEFE);
    lookup(32'h01FF_0000);
    cfg_write(CountAddr, 2);
    lookup(32'h000A_141F);
    lookup(32'h0000_0000);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 86 : 0;
      rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 13 : 0;
      foreach (count_plan[k]) begin
        cfg_write(CountAddr, count_plan[k]);
        if (ph == 2 && k == 0) hold_requests = hold_requests + 1;
        repeat (PerCount) random_request();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- nearest_palette_color_search_top.f -----
rtl/npcs_pkg.sv
rtl/npcs_ram.sv
rtl/npcs_dp.sv
rtl/npcs_ctrl.sv
rtl/nearest_palette_color_search_top.sv
tb/npcs_result_checker.sv
tb/nearest_palette_color_search_top_tb.sv
